FILE: rtl/ipd_pkg.sv
// Shared types, constants and helper functions for the isolated pixel detector.
// No dependencies; every other file of the block but ipd_line_buf imports this package.
package ipd_pkg;

    // Default maximum image size
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    // Payload widths
    localparam int PIX_W   = 8;
    localparam int HIT_W   = 10;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    // Reset value of both image dimensions
    localparam int DIM_RESET = 16;

    // Input command codes and the pixel value that counts as set
    localparam logic             CMD_PIXEL = 1'b0;
    localparam logic             CMD_DRAIN = 1'b1;
    localparam logic [PIX_W-1:0] PIX_SET   = 8'd1;

    // Result queue depth (power of two, room for two pushes per cycle)
    localparam int FIFO_DEPTH = 4;

    // One column of the 3x3 window: rows r-2 (a), r-1 (b), r (s)
    typedef struct packed {
        logic vld;
        logic a;
        logic b;
        logic s;
    } t_col;

    // One report
    typedef struct packed {
        logic [HIT_W-1:0] row;
        logic [HIT_W-1:0] col;
        logic             last;
    } t_hit;

    // Neighbor column holds any set pixel
    function automatic logic col_busy(input t_col col, input logic up);
        return col.vld & ((up & col.a) | col.b | col.s);
    endfunction

    // Candidate column has nothing set above or below the candidate
    function automatic logic col_quiet(input t_col col, input logic up);
        return ~((up & col.a) | col.s);
    endfunction

endpackage

FILE: rtl/ipd_in_if.sv
// Input channel of the isolated pixel detector: one pixel or drain tick per request.
// Depends on ipd_pkg.
interface ipd_in_if import ipd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output command, output pixel, input ready);
    modport sink   (input valid, input command, input pixel, output ready);
endinterface

FILE: rtl/ipd_out_if.sv
// Output channel of the isolated pixel detector: one hit report per request.
// Depends on ipd_pkg.
interface ipd_out_if import ipd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HIT_W-1:0] hit_row;
    logic [HIT_W-1:0] hit_col;
    logic             last;

    modport source (output valid, output hit_row, output hit_col, output last, input ready);
    modport sink   (input valid, input hit_row, input hit_col, input last, output ready);
endinterface

FILE: rtl/ipd_cell.sv
// Window cell: holds one column of the 3x3 window and hands it to the next cell.
// Depends on ipd_pkg.
module ipd_cell import ipd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_clear,
    input  t_col i_col,
    output t_col o_col
);
    t_col r_col;

    // Drop the column at a row boundary or image restart, otherwise advance on shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_clear) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
endmodule

FILE: rtl/ipd_line_buf.sv
// Line buffer memory: per column, the bits of the two rows above the current one.
// Registered read with write-first bypass for a read and write at the same column.
module ipd_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata
);
    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    // Write the column
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read the column, taking fresh data when the same column is written now
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/ipd_out_fifo.sv
// Result queue: takes up to two reports per cycle and delivers one per request.
// Depends on ipd_pkg and ipd_out_if.
module ipd_out_fifo import ipd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_hit       i_hit0,
    input  t_hit       i_hit1,
    output logic       o_room,
    ipd_out_if.source  o_hit
);
    localparam int PW   = $clog2(FIFO_DEPTH);
    localparam int CNTW = PW + 1;

    t_hit            r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;
    logic            pop;
    logic [PW-1:0]   wp_next1;

    assign pop      = o_hit.valid && o_hit.ready;
    assign wp_next1 = r_wp + PW'(1);

    // Store pushed reports
    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_hit0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wp_next1] <= i_hit1;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push_n);
            r_rp  <= r_rp + PW'(pop);
            r_cnt <= r_cnt + CNTW'(i_push_n) - CNTW'(pop);
        end
    end

    // Room for two more reports
    assign o_room = (r_cnt <= CNTW'(FIFO_DEPTH - 2));

    // Present the oldest report
    assign o_hit.valid   = (r_cnt != '0);
    assign o_hit.hit_row = r_mem[r_rp].row;
    assign o_hit.hit_col = r_mem[r_rp].col;
    assign o_hit.last    = r_mem[r_rp].last;
endmodule

FILE: rtl/isolated_pixel_detector.sv
// Isolated pixel detector (3x3, eight neighbors), top level.
// Depends on ipd_pkg, ipd_in_if, ipd_out_if, ipd_cell, ipd_line_buf, ipd_out_fifo.
//
// Takes one pixel request per clock in row-major order while the result queue has room,
// and reports the row and column of every pixel equal to 1 whose eight neighbors are all
// clear. The sustained rate is one input request per cycle while the queue has room, set
// by the single line buffer memory port pair that reads one column and writes it back per
// pixel; a request is held in the window stage register, and its reports enter the result
// queue as it leaves that stage. A pixel's column of the two rows above comes from the
// line buffer, and a chain of two window cells holds the previous two columns, so the
// decision for the pixel up and to the left is made as each pixel passes. The last column
// of a row yields up to two reports, which a four-entry queue absorbs. After the last image
// row, send one row of drain ticks to decide the bottom row; the counters then wrap for a
// new image. A write to the width or height register resets both counters and starts a
// new image. The line buffer needs no clearing after reset.
module isolated_pixel_detector import ipd_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ipd_in_if.sink               i_px,
    ipd_out_if.source            o_hit,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW     = $clog2(MAX_ROWS + 1);
    localparam int RST_W  = (DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET;
    localparam int RST_H  = (DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET;
    localparam int NCELLS = 2;

    // Image geometry
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_h;
    logic [31:0]   cfg_dim;
    logic [31:0]   w_clamp;
    logic [31:0]   h_clamp;
    logic          cfg_restart;

    // Position counters
    logic [CW-1:0] r_col_cnt;
    logic [RW-1:0] r_row_cnt;

    // Window stage
    logic          r_s1_vld;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_set;
    logic          r_s1_last;
    logic          r_s1_en;
    logic          r_s1_up;

    logic          accept;
    logic          fire;
    logic          in_last;
    logic          in_set;
    logic          room;
    logic [1:0]    rdata;
    t_col          chain [NCELLS+1];
    logic          hit_left;
    logic          hit_here;
    logic [1:0]    push_n;
    t_hit          h_left;
    t_hit          h_here;
    t_hit          hit0;
    t_hit          hit1;
    logic [31:0]   col32;
    logic [31:0]   row_m1;

    // Clamp a written dimension to 1..maximum
    assign cfg_dim = 32'(i_cfg_data);
    assign w_clamp = (cfg_dim == 32'd0) ? 32'd1 :
                     (cfg_dim > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cfg_dim;
    assign h_clamp = (cfg_dim == 32'd0) ? 32'd1 :
                     (cfg_dim > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_dim;

    // Only a write to an existing register restarts the image
    assign cfg_restart = i_cfg_we &&
                         (i_cfg_idx == CFG_IDX_WIDTH || i_cfg_idx == CFG_IDX_HEIGHT);

    // Hold the geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= CW'(RST_W - 1);
            r_h        <= RW'(RST_H);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_last_col <= CW'(w_clamp - 32'd1);
                CFG_IDX_HEIGHT: r_h        <= RW'(h_clamp);
                default: ;
            endcase
        end
    end

    // Handshake on the input side and the window stage
    assign fire       = r_s1_vld && room;
    assign i_px.ready = !r_s1_vld || fire;
    assign accept     = i_px.valid && i_px.ready;

    assign in_last = (r_col_cnt == r_last_col);
    assign in_set  = (i_px.command == CMD_PIXEL) && (i_px.pixel == PIX_SET) &&
                     (r_row_cnt < r_h);

    // Advance column and row; a write to the width or height register restarts the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (cfg_restart) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (accept) begin
            if (in_last) begin
                r_col_cnt <= '0;
                r_row_cnt <= (r_row_cnt == r_h) ? '0 : r_row_cnt + RW'(1);
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    // Window stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Capture the request for the window stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col  <= r_col_cnt;
            r_s1_row  <= r_row_cnt;
            r_s1_set  <= in_set;
            r_s1_last <= in_last;
            r_s1_en   <= (r_row_cnt != '0);
            r_s1_up   <= (32'(r_row_cnt) >= 32'd2);
        end
    end

    // Line buffer: read at acceptance, write back the shifted column on fire
    ipd_line_buf #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (r_col_cnt),
        .o_rdata (rdata),
        .i_we    (fire),
        .i_waddr (r_s1_col),
        .i_wdata ({rdata[0], r_s1_set})
    );

    // Current column of the window
    assign chain[0] = '{vld: 1'b1, a: rdata[1], b: rdata[0], s: r_s1_set};

    // Chain of window cells: previous column, then the one before it
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        ipd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (fire),
            .i_clear (cfg_restart || (fire && r_s1_last)),
            .i_col   (chain[g]),
            .o_col   (chain[g+1])
        );
    end

    // Decide the pixel to the upper left, and the upper one at the row end
    assign hit_left = fire && r_s1_en && chain[1].vld && chain[1].b &&
                      col_quiet(chain[1], r_s1_up) &&
                      !col_busy(chain[2], r_s1_up) && !col_busy(chain[0], r_s1_up);
    assign hit_here = fire && r_s1_en && r_s1_last && chain[0].b &&
                      col_quiet(chain[0], r_s1_up) && !col_busy(chain[1], r_s1_up);

    // Build the reports
    assign col32  = 32'(r_s1_col);
    assign row_m1 = 32'(r_s1_row) - 32'd1;
    assign h_left = '{row: row_m1[HIT_W-1:0], col: col32[HIT_W-1:0] - HIT_W'(1),
                      last: !hit_here};
    assign h_here = '{row: row_m1[HIT_W-1:0], col: col32[HIT_W-1:0], last: 1'b1};

    // Pack reports in column order
    assign push_n = {1'b0, hit_left} + {1'b0, hit_here};
    assign hit0   = hit_left ? h_left : h_here;
    assign hit1   = h_here;

    ipd_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_hit0   (hit0),
        .i_hit1   (hit1),
        .o_room   (room),
        .o_hit    (o_hit)
    );
endmodule
